@@ rtl/core/adve_pkg.sv @@
// package for the angle delta velocity estimator
// holds payload types, register codes, reset values and arithmetic constants
// no dependencies
`default_nettype none

package adve_pkg;

    // payload widths fixed by the item format
    localparam int ROTOR_W    = 16;
    localparam int VEL_W      = 24;
    localparam int ELEC_W     = 16;
    localparam int SUM_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic        [ROTOR_W-1:0]    t_rotor_angle;
    typedef logic signed [VEL_W-1:0]      t_velocity;
    typedef logic        [ELEC_W-1:0]     t_elec_angle;
    typedef logic signed [SUM_W-1:0]      t_step_sum;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIMATION_COUNT = 3'd0,
        CFG_ACCUMULATE_COUNT = 3'd1,
        CFG_MAX_STEP         = 3'd2,
        CFG_VELOCITY_SCALE   = 3'd3,
        CFG_POLE_PAIRS       = 3'd4
    } t_cfg_reg;

    // register reset values
    localparam logic [7:0]  RST_DECIMATION_COUNT = 8'd2;
    localparam logic [6:0]  RST_ACCUMULATE_COUNT = 7'd10;
    localparam logic [13:0] RST_MAX_STEP         = 14'd1092;
    localparam logic [15:0] RST_VELOCITY_SCALE   = 16'd60000;
    localparam logic [5:0]  RST_POLE_PAIRS       = 6'd1;

    // velocity limits
    localparam int VEL_MAX = 8388607;
    localparam int VEL_MIN = -8388608;

    // velocity scaling: product of sum and gain, then shift right
    localparam int SCALE_SHIFT = 12;
    localparam int PROD_W      = SUM_W + 17;

    // divide by ten as multiply by reciprocal, exact for magnitudes below 2^27
    localparam int             DIV10_IN_W  = 27;
    localparam int             DIV10_SHIFT = 30;
    localparam logic [26:0]    DIV10_MUL   = 27'd107374183;

    // side information that travels with a transaction through the pipe
    typedef struct packed {
        logic        updated;
        logic        rejected;
        t_elec_angle elec_angle;
    } t_stage_info;

endpackage

`default_nettype wire

@@ rtl/core/adve_if.sv @@
// valid/ready channel interfaces of the angle delta velocity estimator
// depends on adve_pkg
`default_nettype none

// angle sample channel
interface adve_in_if;
    logic                  valid;
    logic                  ready;
    adve_pkg::t_rotor_angle rotor_angle;

    modport source (output valid, output rotor_angle, input ready);
    modport sink   (input valid, input rotor_angle, output ready);
endinterface

// result channel
interface adve_out_if;
    logic                  valid;
    logic                  ready;
    adve_pkg::t_velocity   mech_velocity;
    logic                  velocity_updated;
    logic                  step_rejected;
    adve_pkg::t_elec_angle electrical_angle;

    modport source (output valid, output mech_velocity, output velocity_updated,
                    output step_rejected, output electrical_angle, input ready);
    modport sink   (input valid, input mech_velocity, input velocity_updated,
                    input step_rejected, input electrical_angle, output ready);
endinterface

// configuration write channel
interface adve_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [adve_pkg::CFG_IDX_W-1:0] index;
    adve_pkg::t_cfg_data           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/angle_delta_velocity_estimator_core.sv @@
// angle delta velocity estimator: one result transaction per angle sample,
// accepted every cycle; the result is registered through stage one, stage two
// and the output stage (state update, scaling multiply, filter with divide by ten).
// throughput is one transaction per cycle unless the result side stalls.
// synchronous active-low reset clears the counters, sum, previous angle and
// filtered velocity and loads the register defaults
`default_nettype none

module angle_delta_velocity_estimator_core #(
    parameter int ANGLE_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    adve_in_if.sink     i_in,
    adve_cfg_if.sink    i_cfg,
    adve_out_if.source  o_out
);

    localparam int IN_W  = (ANGLE_BITS < adve_pkg::ROTOR_W) ? ANGLE_BITS : adve_pkg::ROTOR_W;
    localparam int MAG_W = ANGLE_BITS + 1;
    localparam int CMP_W = (MAG_W > 14) ? MAG_W : 14;
    localparam int SW    = adve_pkg::SUM_W;

    // configuration registers
    logic [7:0]              r_dec;
    logic [6:0]              r_acc;
    logic [13:0]             r_max;
    logic [15:0]             r_scale;
    logic [5:0]              r_pp;

    // estimator state
    logic [7:0]              r_tick;
    logic [6:0]              r_samp;
    adve_pkg::t_step_sum     r_sum;
    logic [ANGLE_BITS-1:0]   r_prev;

    // stage one
    logic                    r_s1_valid;
    adve_pkg::t_step_sum     r_s1_sum;
    adve_pkg::t_stage_info   r_s1_info;

    logic                    n_s1_valid_unused;
    logic [7:0]              n_tick;
    logic [6:0]              n_samp;
    adve_pkg::t_step_sum     n_sum;
    logic [ANGLE_BITS-1:0]   n_prev;
    adve_pkg::t_stage_info   n_info;

    logic                    w_s2_ready;
    logic                    w_in_fire;
    logic [ANGLE_BITS-1:0]   w_angle;
    logic [ANGLE_BITS-1:0]   w_diff;
    logic signed [ANGLE_BITS-1:0] w_d;
    logic signed [MAG_W-1:0] w_dx;
    logic [MAG_W-1:0]        w_mag;
    logic                    w_too_big;
    adve_pkg::t_step_sum     w_step;
    adve_pkg::t_step_sum     w_sum;
    logic [8:0]              w_tick;
    logic [7:0]              w_samp;
    logic                    w_used;
    logic                    w_update;
    logic [ANGLE_BITS+5:0]   w_eprod;

    assign i_in.ready = !r_s1_valid || w_s2_ready;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign n_s1_valid_unused = 1'b0;

    // angle difference and step rejection
    always_comb begin
        w_angle   = ANGLE_BITS'(i_in.rotor_angle[IN_W-1:0]);
        w_diff    = w_angle - r_prev;
        w_d       = $signed(w_diff);
        w_dx      = MAG_W'(w_d);
        w_mag     = $unsigned(w_dx[MAG_W-1] ? -w_dx : w_dx);
        w_too_big = CMP_W'(w_mag) > CMP_W'(r_max);
        w_step    = w_too_big ? '0 : SW'(w_d);
        w_sum     = r_sum + w_step;
        w_eprod   = (ANGLE_BITS+6)'(w_angle) * (ANGLE_BITS+6)'(r_pp);
    end

    // counters and next state
    always_comb begin
        w_tick   = {1'b0, r_tick} + 9'd1;
        w_samp   = {1'b0, r_samp} + 8'd1;
        w_used   = w_tick >= {1'b0, r_dec};
        w_update = w_used && (w_samp >= {1'b0, r_acc});
        n_tick   = r_tick;
        n_samp   = r_samp;
        n_sum    = r_sum;
        n_prev   = r_prev;
        if (w_used) begin
            n_tick = '0;
            n_prev = w_angle;
            if (w_update) begin
                n_samp = '0;
                n_sum  = '0;
            end else begin
                n_samp = w_samp[6:0];
                n_sum  = w_sum;
            end
        end else begin
            n_tick = w_tick[7:0];
        end
        n_info.updated    = w_update;
        n_info.rejected   = w_used && w_too_big;
        n_info.elec_angle = adve_pkg::ELEC_W'(w_eprod[ANGLE_BITS-1:0]);
    end

    // configuration writes and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec      <= adve_pkg::RST_DECIMATION_COUNT;
            r_acc      <= adve_pkg::RST_ACCUMULATE_COUNT;
            r_max      <= adve_pkg::RST_MAX_STEP;
            r_scale    <= adve_pkg::RST_VELOCITY_SCALE;
            r_pp       <= adve_pkg::RST_POLE_PAIRS;
            r_tick     <= '0;
            r_samp     <= '0;
            r_sum      <= '0;
            r_prev     <= '0;
            r_s1_valid <= n_s1_valid_unused;
        end else begin
            if (i_cfg.valid) begin
                case (adve_pkg::t_cfg_reg'(i_cfg.index))
                    adve_pkg::CFG_DECIMATION_COUNT: r_dec   <= i_cfg.data[7:0];
                    adve_pkg::CFG_ACCUMULATE_COUNT: r_acc   <= i_cfg.data[6:0];
                    adve_pkg::CFG_MAX_STEP:         r_max   <= i_cfg.data[13:0];
                    adve_pkg::CFG_VELOCITY_SCALE:   r_scale <= i_cfg.data[15:0];
                    adve_pkg::CFG_POLE_PAIRS:       r_pp    <= i_cfg.data[5:0];
                    default: begin
                    end
                endcase
            end
            if (w_in_fire) begin
                r_tick <= n_tick;
                r_samp <= n_samp;
                r_sum  <= n_sum;
                r_prev <= n_prev;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
        end
    end

    // stage one payload: sum at the update and side information
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_sum  <= w_sum;
            r_s1_info <= n_info;
        end
    end

    // scaling and smoothing stages
    adve_filter u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s1_valid       (r_s1_valid),
        .o_s1_ready       (w_s2_ready),
        .i_s1_sum         (r_s1_sum),
        .i_s1_info        (r_s1_info),
        .i_velocity_scale (r_scale),
        .o_out            (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/adve_filter.sv @@
// velocity scaling and smoothing filter stages, driving the result channel
// depends on adve_pkg and adve_if
`default_nettype none

module adve_filter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s1_valid,
    output logic                 o_s1_ready,
    input  wire adve_pkg::t_step_sum  i_s1_sum,
    input  wire adve_pkg::t_stage_info i_s1_info,
    input  wire  [15:0]          i_velocity_scale,
    adve_out_if.source           o_out
);

    localparam int PW = adve_pkg::PROD_W;
    localparam int DW = adve_pkg::DIV10_IN_W;
    localparam int QW = adve_pkg::VEL_W;
    localparam int MW = DW + adve_pkg::DIV10_IN_W;

    // stage two: scaled product
    logic                   r_s2_valid;
    logic signed [PW-1:0]   r_prod;
    adve_pkg::t_stage_info  r_s2_info;

    // output stage
    logic                   r_out_valid;
    adve_pkg::t_velocity    r_filt;
    adve_pkg::t_stage_info  r_out_info;

    logic                   w_ld2;
    logic                   w_ld3;
    logic                   w_s2_ready;
    logic signed [PW-1:0]   w_prod;

    logic signed [PW-1:0]   w_shift;
    adve_pkg::t_velocity    w_new_vel;
    logic signed [28:0]     w_acc;
    logic                   w_neg;
    logic [DW-1:0]          w_mag;
    logic [MW-1:0]          w_recip;
    logic [QW-1:0]          w_quot;
    logic signed [QW:0]     w_quot_s;
    adve_pkg::t_velocity    n_filt;

    // pipeline handshake
    assign w_ld3      = r_s2_valid && (!r_out_valid || o_out.ready);
    assign w_s2_ready = !r_s2_valid || !r_out_valid || o_out.ready;
    assign w_ld2      = i_s1_valid && w_s2_ready;
    assign o_s1_ready = w_s2_ready;

    // sum times gain
    assign w_prod = PW'(i_s1_sum) * PW'($signed({1'b0, i_velocity_scale}));

    // floor shift and saturation of the new velocity
    always_comb begin
        w_shift = r_prod >>> adve_pkg::SCALE_SHIFT;
        if (w_shift > PW'(adve_pkg::VEL_MAX)) begin
            w_new_vel = adve_pkg::t_velocity'(adve_pkg::VEL_MAX);
        end else if (w_shift < PW'(adve_pkg::VEL_MIN)) begin
            w_new_vel = adve_pkg::t_velocity'(adve_pkg::VEL_MIN);
        end else begin
            w_new_vel = w_shift[QW-1:0];
        end
    end

    // (9v + new) / 10, truncated toward zero
    always_comb begin
        w_acc    = 29'(r_filt) * 29'sd9 + 29'(w_new_vel);
        w_neg    = w_acc[28];
        w_mag    = w_neg ? DW'(-w_acc) : DW'(w_acc);
        w_recip  = MW'(w_mag) * MW'(adve_pkg::DIV10_MUL);
        w_quot   = w_recip[adve_pkg::DIV10_SHIFT +: QW];
        w_quot_s = w_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        if (w_quot_s > (QW+1)'(adve_pkg::VEL_MAX)) begin
            n_filt = adve_pkg::t_velocity'(adve_pkg::VEL_MAX);
        end else if (w_quot_s < (QW+1)'(adve_pkg::VEL_MIN)) begin
            n_filt = adve_pkg::t_velocity'(adve_pkg::VEL_MIN);
        end else begin
            n_filt = w_quot_s[QW-1:0];
        end
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_filt      <= '0;
        end else begin
            if (w_s2_ready) begin
                r_s2_valid <= i_s1_valid;
            end
            if (!r_out_valid || o_out.ready) begin
                r_out_valid <= r_s2_valid;
            end
            if (w_ld3 && r_s2_info.updated) begin
                r_filt <= n_filt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_prod    <= w_prod;
            r_s2_info <= i_s1_info;
        end
        if (w_ld3) begin
            r_out_info <= r_s2_info;
        end
    end

    // result channel
    assign o_out.valid            = r_out_valid;
    assign o_out.mech_velocity    = r_filt;
    assign o_out.velocity_updated = r_out_info.updated;
    assign o_out.step_rejected    = r_out_info.rejected;
    assign o_out.electrical_angle = r_out_info.elec_angle;

endmodule

`default_nettype wire
